// ===== hdl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// Cache tag controller package
// Shared types and constants, among them the address field widths, for the
// set-associative cache tag and metadata controller.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int SETS             = 64;
  localparam int WAYS             = 4;
  localparam int ADDR_W           = 32;
  localparam int LINE_OFFSET_BITS = 6;

  localparam int IDX_W   = $clog2(SETS);
  localparam int WAY_W   = 2;
  localparam int TAG_W   = ADDR_W - LINE_OFFSET_BITS - IDX_W;
  localparam int LRU_W   = 2;
  localparam int EADDR_W = 26;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 2;

  // Request kinds.
  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_LOCK    = 2'd2;
  localparam logic [1:0] KIND_RELEASE = 2'd3;

  // Outcomes.
  localparam logic [1:0] OUT_HIT     = 2'd0;
  localparam logic [1:0] OUT_FILL    = 2'd1;
  localparam logic [1:0] OUT_IGNORED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_LRU  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WT_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOCKS = 2'd2;

  // Classified request handed from front to back.
  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] set;
    logic [TAG_W-1:0] tag;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]         outcome;
    logic [WAY_W-1:0]   used_way;
    logic               lock_result;
    logic               evict_dirty;
    logic [EADDR_W-1:0] evict_line_address;
    logic               write_through_issued;
  } rsp_t;

endpackage

// ===== hdl/salc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/salc_front.sv =====
// ----------------------------------------------------------------------------
// Cache tag controller front end
// Accepts requests, splits the address into set and tag and pushes the
// classified request into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module salc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_kind,
  input  logic [31:0]          in_address,
  output logic                 req_valid,
  output salc_pkg::req_t       req,
  input  logic                 req_take
);

  salc_pkg::req_t q_r [2];
  logic           rd_ptr_r, rd_ptr_nxt;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;
  salc_pkg::req_t new_req;

  // Address split.
  always_comb begin
    new_req.kind = in_kind;
    new_req.set  = in_address[salc_pkg::LINE_OFFSET_BITS +: salc_pkg::IDX_W];
    new_req.tag  = in_address[salc_pkg::ADDR_W-1 -: salc_pkg::TAG_W];
  end

  assign in_full   = (cnt_r == 2'd2);
  assign do_push   = in_push && !in_full;
  assign req_valid = (cnt_r != 2'd0);
  assign do_pop    = req_valid && req_take;
  assign req       = q_r[rd_ptr_r];

  // Queue pointers.
  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= new_req;
    end
  end

endmodule

// ===== hdl/salc_back.sv =====
// ----------------------------------------------------------------------------
// Cache tag controller back end
// Looks up one request at a time: reads the tag and metadata RAMs, compares
// the ways, picks a victim, writes the set back and queues the result.
// After reset it first walks every set and writes the initial metadata.
// ----------------------------------------------------------------------------
module salc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  input  salc_pkg::req_t       req,
  output logic                 req_take,
  input  logic                 cfg_fill_lru,
  input  logic                 cfg_wt_mode,
  input  logic [1:0]           cfg_max_locks,
  output logic                 out_empty,
  input  logic                 out_pop,
  output salc_pkg::rsp_t       rsp
);

  localparam int W  = salc_pkg::WAYS;
  localparam int SN = salc_pkg::SETS;
  localparam int TW = salc_pkg::TAG_W;
  localparam int IW = salc_pkg::IDX_W;
  localparam int LW = salc_pkg::LRU_W;
  localparam int AW = salc_pkg::WAY_W;
  localparam int MW = W * (3 + LW);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [IW-1:0]  clr_r, clr_nxt;
  salc_pkg::req_t cur_r;
  logic           rsp_full_r;
  salc_pkg::rsp_t rsp_r, rsp_nxt;

  logic [TW*W-1:0] tag_rd;
  logic            tag_we;
  logic [TW*W-1:0] tag_wd;

  // Metadata row: valid, dirty and lock bits, then the LRU counters.
  logic [MW-1:0]   meta_rd;
  logic            meta_we;
  logic [IW-1:0]   meta_waddr;
  logic [MW-1:0]   meta_wd;
  logic [MW-1:0]   meta_init;
  logic [MW-1:0]   meta_new;
  logic            clearing;

  logic [W-1:0]  v, d, lk, v_n, d_n, lk_n;
  logic [LW-1:0] lru [W];
  logic [LW-1:0] lru_n [W];
  logic [W-1:0]  match;
  logic          hit;
  logic [AW-1:0] hway, vway, uway;
  logic [LW-1:0] vlru;
  logic [2:0]    nlock;
  logic          lock_ok;
  logic          done;

  // Tag RAM holds one set per row.
  salc_ram #(.WIDTH(TW*W), .DEPTH(SN)) u_tag (
    .clk   (clk),
    .we    (tag_we),
    .waddr (cur_r.set),
    .wdata (tag_wd),
    .raddr (req.set),
    .rdata (tag_rd)
  );

  // Metadata RAM, one set per row, read together with the tags.
  salc_ram #(.WIDTH(MW), .DEPTH(SN)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wd),
    .raddr (req.set),
    .rdata (meta_rd)
  );

  assign clearing  = (state_r == ST_CLEAR);
  assign req_take  = (state_r == ST_IDLE) && !rsp_full_r;
  assign done      = (state_r == ST_LOOK);
  assign out_empty = !rsp_full_r;
  assign rsp       = rsp_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(SN-1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid && req_take) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Initial row: no valid, dirty or locked way, LRU count equal to the way.
  always_comb begin
    meta_init = '0;
    for (int i = 0; i < W; i++) meta_init[3*W + i*LW +: LW] = LW'(i);
  end

  // Metadata write: the clearing pass first, then one row per request.
  always_comb begin
    meta_we    = clearing || done;
    meta_waddr = clearing ? clr_r : cur_r.set;
    meta_wd    = clearing ? meta_init : meta_new;
  end

  // Lookup, victim choice and metadata update.
  always_comb begin
    v  = meta_rd[0 +: W];
    d  = meta_rd[W +: W];
    lk = meta_rd[2*W +: W];
    for (int i = 0; i < W; i++) begin
      lru[i]   = meta_rd[3*W + i*LW +: LW];
      match[i] = v[i] && (tag_rd[i*TW +: TW] == cur_r.tag);
    end
    hit  = |match;
    hway = '0;
    for (int i = W-1; i >= 0; i--) begin
      if (match[i]) hway = AW'(i);
    end
    vway = '0;
    vlru = '0;
    for (int i = 0; i < W; i++) begin
      if (!(|(match & ((W'(1) << i) - W'(1))))) begin
        if (!match[i] && lru[i] >= vlru && !lk[i]) begin
          vway = AW'(i);
          vlru = lru[i];
        end
      end
    end
    uway = hit ? hway : vway;
    v_n  = v;
    d_n  = d;
    lk_n = lk;
    for (int i = 0; i < W; i++) lru_n[i] = lru[i];
    tag_we = 1'b0;
    tag_wd = tag_rd;
    tag_wd[uway*TW +: TW] = cur_r.tag;
    nlock = '0;
    for (int i = 0; i < W; i++) nlock = nlock + {2'b0, lk[i]};
    lock_ok = nlock < {1'b0, cfg_max_locks};
    rsp_nxt = '0;
    rsp_nxt.used_way = uway;
    if (hit && cur_r.kind == salc_pkg::KIND_RELEASE) begin
      rsp_nxt.outcome     = salc_pkg::OUT_HIT;
      rsp_nxt.lock_result = !lk[hway];
      lk_n[hway]          = 1'b0;
    end else if (!hit && cur_r.kind == salc_pkg::KIND_RELEASE) begin
      rsp_nxt.outcome     = salc_pkg::OUT_IGNORED;
      rsp_nxt.used_way    = '0;
      rsp_nxt.lock_result = 1'b1;
    end else begin
      rsp_nxt.outcome = hit ? salc_pkg::OUT_HIT : salc_pkg::OUT_FILL;
      if (!hit) begin
        if (v[vway]) begin
          rsp_nxt.evict_dirty = d[vway];
          rsp_nxt.evict_line_address =
            salc_pkg::EADDR_W'({tag_rd[vway*TW +: TW], cur_r.set});
        end
        d_n[vway] = 1'b0;
        v_n[vway] = 1'b1;
        tag_we    = done;
      end
      if (hit || cfg_fill_lru) begin
        for (int i = 0; i < W; i++) begin
          if (lru[i] < lru[uway]) lru_n[i] = lru[i] + LW'(1);
        end
        lru_n[uway] = '0;
      end
      if (cur_r.kind == salc_pkg::KIND_LOCK) begin
        rsp_nxt.lock_result = !lock_ok;
        if (lock_ok) lk_n[uway] = 1'b1;
      end
      if (cur_r.kind == salc_pkg::KIND_WRITE) begin
        if (cfg_wt_mode) rsp_nxt.write_through_issued = 1'b1;
        else d_n[uway] = 1'b1;
      end
    end
    meta_new = {{MW-3*W{1'b0}}, lk_n, d_n, v_n};
    for (int i = 0; i < W; i++) meta_new[3*W + i*LW +: LW] = lru_n[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      rsp_full_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (done) begin
        rsp_full_r <= 1'b1;
      end else if (out_pop && rsp_full_r) begin
        rsp_full_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_valid && req_take) cur_r <= req;
    if (done) rsp_r <= rsp_nxt;
  end

endmodule

// ===== hdl/set_assoc_cache_lru_lock_tags.sv =====
// ----------------------------------------------------------------------------
// Set-associative cache tag controller with LRU and way locking
// Top level: configuration registers, front end and back end.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-style port: drive in_kind and in_address
//   and raise in_push; the request is taken on a clock edge where in_full is
//   low. Results leave the same way: while out_empty is low the oldest
//   result sits on the out_ ports, and out_pop takes it.
//   The front end splits the address and buffers up to two requests. The
//   back end reads the set's tag and metadata rows as it takes a request,
//   then in its lookup state compares, picks a victim and writes the rows
//   back; the result is registered. The back end takes a new request only
//   after its single result has been popped. While the result waits the
//   front queue fills, then in_full rises.
//   After reset (rst_n low, synchronous) the back end writes every set's
//   initial metadata; requests queue meanwhile. Reset also loads the
//   configuration defaults. Write cfg_ registers only while idle.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lock_tags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_address,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_outcome,
  output logic [1:0]  out_used_way,
  output logic        out_lock_result,
  output logic        out_evict_dirty,
  output logic [25:0] out_evict_line_address,
  output logic        out_write_through_issued,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  logic           fill_lru_r;
  logic           wt_mode_r;
  logic [1:0]     max_locks_r;
  logic           req_valid;
  logic           req_take;
  salc_pkg::req_t req;
  salc_pkg::rsp_t rsp;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_lru_r  <= 1'b1;
      wt_mode_r   <= 1'b0;
      max_locks_r <= 2'd3;
    end else if (cfg_we) begin
      if (cfg_index == salc_pkg::CFG_FILL_LRU)  fill_lru_r  <= cfg_data[0];
      if (cfg_index == salc_pkg::CFG_WT_MODE)   wt_mode_r   <= cfg_data[0];
      if (cfg_index == salc_pkg::CFG_MAX_LOCKS) max_locks_r <= cfg_data;
    end
  end

  salc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_kind    (in_kind),
    .in_address (in_address),
    .req_valid  (req_valid),
    .req        (req),
    .req_take   (req_take)
  );

  salc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req           (req),
    .req_take      (req_take),
    .cfg_fill_lru  (fill_lru_r),
    .cfg_wt_mode   (wt_mode_r),
    .cfg_max_locks (max_locks_r),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .rsp           (rsp)
  );

  assign out_outcome              = rsp.outcome;
  assign out_used_way             = rsp.used_way;
  assign out_lock_result          = rsp.lock_result;
  assign out_evict_dirty          = rsp.evict_dirty;
  assign out_evict_line_address   = rsp.evict_line_address;
  assign out_write_through_issued = rsp.write_through_issued;

endmodule

// ===== verif/cache_tag_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag controller checker
// Watches the request and result channels of the cache tag controller,
// keeps its own copy of the tag, valid, dirty, lock and LRU state, predicts
// each result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module cache_tag_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_address,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [1:0]  out_outcome,
  input  logic [1:0]  out_used_way,
  input  logic        out_lock_result,
  input  logic        out_evict_dirty,
  input  logic [25:0] out_evict_line_address,
  input  logic        out_write_through_issued,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  // Shadow copy of the block's metadata and configuration.
  logic [salc_pkg::TAG_W-1:0] tags   [salc_pkg::SETS][salc_pkg::WAYS];
  logic                       valid  [salc_pkg::SETS][salc_pkg::WAYS];
  logic                       dirty  [salc_pkg::SETS][salc_pkg::WAYS];
  logic                       locked [salc_pkg::SETS][salc_pkg::WAYS];
  logic [salc_pkg::LRU_W-1:0] age    [salc_pkg::SETS][salc_pkg::WAYS];
  logic                       fill_lru;
  logic                       wt_mode;
  logic [1:0]                 lock_limit;

  salc_pkg::rsp_t expected_rsps[$];

  // Move one way to most recently used and age the younger ones.
  function automatic void make_newest(int s, int w);
    logic [salc_pkg::LRU_W-1:0] cur;
    cur = age[s][w];
    for (int i = 0; i < salc_pkg::WAYS; i++)
      if (age[s][i] < cur) age[s][i]++;
    age[s][w] = '0;
  endfunction

  // Lock a way if the set's lock count is still under the limit.
  function automatic logic lock_way(int s, int w);
    int cnt;
    cnt = 0;
    for (int i = 0; i < salc_pkg::WAYS; i++)
      if (locked[s][i]) cnt++;
    if (cnt < int'(lock_limit)) begin
      locked[s][w] = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Work out the result of one access and update the shadow state.
  function automatic salc_pkg::rsp_t predict_access(logic [1:0] kind, logic [31:0] addr);
    salc_pkg::rsp_t r;
    int s, w, vway, hway;
    logic [salc_pkg::TAG_W-1:0] tg;
    logic [salc_pkg::LRU_W-1:0] vage;
    logic hit;
    r = '0;
    s = int'(addr[salc_pkg::LINE_OFFSET_BITS +: salc_pkg::IDX_W]);
    tg = addr[31 -: salc_pkg::TAG_W];
    hit = 1'b0;
    vway = 0;
    vage = '0;
    hway = 0;
    for (w = 0; w < salc_pkg::WAYS; w++) begin
      if (valid[s][w] && tags[s][w] == tg) begin
        hit = 1'b1;
        hway = w;
        break;
      end
      if (age[s][w] >= vage && !locked[s][w]) begin
        vway = w;
        vage = age[s][w];
      end
    end
    if (hit) begin
      r.outcome = salc_pkg::OUT_HIT;
      r.used_way = salc_pkg::WAY_W'(hway);
      if (kind == salc_pkg::KIND_RELEASE) begin
        r.lock_result = !locked[s][hway];
        locked[s][hway] = 1'b0;
      end else begin
        if (kind == salc_pkg::KIND_LOCK) r.lock_result = lock_way(s, hway);
        make_newest(s, hway);
        if (kind == salc_pkg::KIND_WRITE) begin
          if (wt_mode) r.write_through_issued = 1'b1;
          else dirty[s][hway] = 1'b1;
        end
      end
    end else if (kind == salc_pkg::KIND_RELEASE) begin
      r.outcome = salc_pkg::OUT_IGNORED;
      r.lock_result = 1'b1;
    end else begin
      r.outcome = salc_pkg::OUT_FILL;
      r.used_way = salc_pkg::WAY_W'(vway);
      if (valid[s][vway]) begin
        r.evict_line_address = {tags[s][vway], s[salc_pkg::IDX_W-1:0]};
        r.evict_dirty = dirty[s][vway];
      end
      dirty[s][vway] = 1'b0;
      tags[s][vway] = tg;
      valid[s][vway] = 1'b1;
      if (fill_lru) make_newest(s, vway);
      if (kind == salc_pkg::KIND_LOCK) r.lock_result = lock_way(s, vway);
      if (kind == salc_pkg::KIND_WRITE) begin
        if (wt_mode) r.write_through_issued = 1'b1;
        else dirty[s][vway] = 1'b1;
      end
    end
    return r;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    salc_pkg::rsp_t e;
    if (!rst_n) begin
      for (int s = 0; s < salc_pkg::SETS; s++)
        for (int w = 0; w < salc_pkg::WAYS; w++) begin
          valid[s][w] = 1'b0;
          dirty[s][w] = 1'b0;
          locked[s][w] = 1'b0;
          age[s][w] = salc_pkg::LRU_W'(w);
        end
      fill_lru = 1'b1;
      wt_mode = 1'b0;
      lock_limit = 2'd3;
      expected_rsps.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          salc_pkg::CFG_FILL_LRU:  fill_lru = cfg_data[0];
          salc_pkg::CFG_WT_MODE:   wt_mode = cfg_data[0];
          salc_pkg::CFG_MAX_LOCKS: lock_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full)
        expected_rsps.push_back(predict_access(in_kind, in_address));
      // The result check runs after the prediction; a request cannot turn
      // into a result in the same cycle, so the order does not matter.
      if (out_pop && !out_empty) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: result with nothing expected", $realtime);
          fail_count++;
        end else begin
          e = expected_rsps.pop_front();
          if (out_outcome !== e.outcome)
            report_mismatch("outcome", out_outcome, e.outcome);
          if (out_used_way !== e.used_way)
            report_mismatch("used_way", out_used_way, e.used_way);
          if (out_lock_result !== e.lock_result)
            report_mismatch("lock_result", out_lock_result, e.lock_result);
          if (out_evict_dirty !== e.evict_dirty)
            report_mismatch("evict_dirty", out_evict_dirty, e.evict_dirty);
          if (out_evict_line_address !== e.evict_line_address)
            report_mismatch("evict_line_address", out_evict_line_address,
                            e.evict_line_address);
          if (out_write_through_issued !== e.write_through_issued)
            report_mismatch("write_through_issued", out_write_through_issued,
                            e.write_through_issued);
        end
      end
    end
    pending = expected_rsps.size();
  end

endmodule

// ===== verif/tb_set_assoc_cache_lru_lock_tags.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag controller testbench
// Drives directed and random cache accesses through several configurations
// and idling phases; a separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_lock_tags;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_kind;
  logic [31:0] in_address;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_outcome;
  logic [1:0]  out_used_way;
  logic        out_lock_result;
  logic        out_evict_dirty;
  logic [25:0] out_evict_line_address;
  logic        out_write_through_issued;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [1:0]  cfg_data;
  int          fail_count;
  int          pending;

  // Receiver stall percentage and forced hold-off length; sender idle percentage.
  int          pop_stall_pct;
  int          hold_cycles;
  int          send_idle_pct;

  set_assoc_cache_lru_lock_tags dut (.*);

  cache_tag_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Generous overall limit.
  initial begin
    #20ms;
    $display("set_assoc_cache_lru_lock_tags verification failed");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Offer one request and hold it until it is taken; push stays high
  // until the next request or an idle cycle replaces it.
  task automatic send_request(logic [1:0] kind, logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_kind <= kind;
    in_address <= addr;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait for every expected result, then let the pipeline settle.
  task automatic drain;
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // One register write, with the write enable dropped again afterwards.
  task automatic write_reg(logic [1:0] idx, logic [1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Address built from a set, a tag and a random line offset.
  function automatic logic [31:0] make_addr(int s, logic [salc_pkg::TAG_W-1:0] tg);
    logic [31:0] a;
    a = {tg, s[salc_pkg::IDX_W-1:0], 6'(($urandom()))};
    return a;
  endfunction

  // Random batch: mostly a few hot sets with a handful of tags each, so
  // hits, fills, evictions and locks keep happening; some pure noise.
  task automatic random_batch(int count);
    int s;
    logic [1:0] kind;
    logic [31:0] addr;
    for (int i = 0; i < count; i++) begin
      kind = 2'($urandom_range(3));
      if ($urandom_range(9) == 0) begin
        addr = $urandom();
      end else begin
        s = $urandom_range(3) * 21;
        addr = make_addr(s, salc_pkg::TAG_W'($urandom_range(6)) ^
                         ($urandom_range(3) == 0 ? {salc_pkg::TAG_W{1'b1}} : '0));
      end
      send_request(kind, addr);
    end
  endtask

  initial begin
    logic [salc_pkg::TAG_W-1:0] ones;
    ones = '1;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_kind = salc_pkg::KIND_READ;
    in_address = '0;
    cfg_we = 1'b0;
    cfg_index = salc_pkg::CFG_FILL_LRU;
    cfg_data = '0;
    hold_cycles = 0;
    pop_stall_pct = 0;
    send_idle_pct = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every kind, lock limit reached,
    // release hit and miss, dirty eviction.
    send_request(salc_pkg::KIND_RELEASE, 32'h0);
    send_request(salc_pkg::KIND_READ, 32'h0);
    send_request(salc_pkg::KIND_WRITE, 32'hFFFF_FFFF);
    send_request(salc_pkg::KIND_RELEASE, 32'h0);
    for (int t = 0; t < 5; t++)
      send_request(salc_pkg::KIND_LOCK, make_addr(5, salc_pkg::TAG_W'(t)));
    send_request(salc_pkg::KIND_RELEASE, make_addr(5, salc_pkg::TAG_W'(4)));
    send_request(salc_pkg::KIND_RELEASE, make_addr(5, salc_pkg::TAG_W'(4)));
    for (int t = 0; t < 5; t++)
      send_request(salc_pkg::KIND_WRITE, make_addr(9, ones ^ salc_pkg::TAG_W'(t)));
    send_request(salc_pkg::KIND_READ, make_addr(9, ones));
    send_request(salc_pkg::KIND_RELEASE, make_addr(9, ones));
    send_request(salc_pkg::KIND_LOCK, 32'hAAAA_AAAA);
    send_request(salc_pkg::KIND_READ, 32'h5555_5555);
    drain();

    // Write-through, no LRU on fill, no locking allowed, then up to three locks.
    write_reg(salc_pkg::CFG_WT_MODE, 2'd1);
    write_reg(salc_pkg::CFG_FILL_LRU, 2'd0);
    write_reg(salc_pkg::CFG_MAX_LOCKS, 2'd0);
    random_batch(300);
    drain();
    write_reg(salc_pkg::CFG_MAX_LOCKS, 2'd3);
    send_idle_pct = 70;
    random_batch(300);
    drain();

    // Write-back with LRU fill, lock limit 1, receiver stalling.
    write_reg(salc_pkg::CFG_WT_MODE, 2'd0);
    write_reg(salc_pkg::CFG_FILL_LRU, 2'd1);
    write_reg(salc_pkg::CFG_MAX_LOCKS, 2'd1);
    send_idle_pct = 0;
    pop_stall_pct = 70;
    random_batch(300);
    drain();

    // Long receiver hold-off while requests keep coming.
    pop_stall_pct = 0;
    hold_cycles = 200;
    write_reg(salc_pkg::CFG_MAX_LOCKS, 2'd2);
    random_batch(250);
    drain();

    // Both sides idling, then no idling with the defaults back.
    send_idle_pct = 20;
    pop_stall_pct = 20;
    write_reg(salc_pkg::CFG_FILL_LRU, 2'd0);
    random_batch(350);
    drain();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    write_reg(salc_pkg::CFG_FILL_LRU, 2'd1);
    write_reg(salc_pkg::CFG_MAX_LOCKS, 2'd3);
    random_batch(430);
    drain();

    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("set_assoc_cache_lru_lock_tags verification clean");
    else
      $display("set_assoc_cache_lru_lock_tags verification failed");
    $finish;
  end

endmodule
